// ===== hw/rtl/dns_name_wire_to_dotted_text_top_assert.svh =====
// ----------------------------------------------------------------------------
// DNS name wire-to-text assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_WIRE_TO_DOTTED_TEXT_TOP_ASSERT_SVH
`define DNS_NAME_WIRE_TO_DOTTED_TEXT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold.
`define W2T_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dnsw2t: implication check failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define W2T_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dnsw2t: next-cycle check failed");
`else
`define W2T_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define W2T_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/dnsw2t_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS name wire-to-text package
// Shared types, character constants and classification functions.
// ----------------------------------------------------------------------------
package dnsw2t_pkg;

  // Character constants
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [2:0] OCT_MASK    = 3'd7;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;

  // Escape sequence positions
  localparam logic [1:0] ESC_SLASH = 2'd0;
  localparam logic [1:0] ESC_HIGH  = 2'd1;
  localparam logic [1:0] ESC_MID   = 2'd2;
  localparam logic [1:0] ESC_LOW   = 2'd3;

  // Operation kinds passed from front to back
  typedef enum logic [1:0] {
    OP_TEXT = 2'd0,  // one character
    OP_ESC  = 2'd1,  // backslash plus three octal digits
    OP_MARK = 2'd2   // bare end-of-name marker
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
    logic       done;
  } op_t;

  // Fold upper-case letters to lower case
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  // Characters that are sent without escaping
  function automatic logic plain_char(input logic [7:0] c);
    return (c inside {[CH_LOWER_A:CH_LOWER_Z], [CH_ZERO:CH_DIGIT_9], CH_DASH, CH_UNDER});
  endfunction

  // Octal digit character for a three-bit group
  function automatic logic [7:0] oct_char(input logic [2:0] d);
    return CH_ZERO + {5'd0, d & OCT_MASK};
  endfunction

endpackage

// ===== hw/rtl/dnsw2t_if.sv =====
// ----------------------------------------------------------------------------
// DNS name wire-to-text channel interfaces
// Valid/ready channels for wire bytes in and text results out.
// ----------------------------------------------------------------------------
interface dnsw2t_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dnsw2t_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       run_last;
  logic       name_done;

  modport source (output valid, output text_byte, output has_byte, output run_last,
                  output name_done, input ready);
  modport sink   (input valid, input text_byte, input has_byte, input run_last,
                  input name_done, output ready);
endinterface

// ===== hw/rtl/dns_name_wire_to_dotted_text_top.sv =====
// ----------------------------------------------------------------------------
// DNS name wire-to-text top level
// Converts wire-format DNS names, one byte per transfer, to dotted text.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                    role
//   in_i     in   in_byte[7:0]                               wire bytes
//   out_o    out  text_byte[7:0] has_byte run_last name_done text results
//
// One wire byte is taken per cycle while the op queue has room.
// The back end sends one result per cycle while out_o.ready allows: plain bytes,
// dots and end markers give one result each, an escaped byte gives four, so
// escapes set the rate there. Lengths that open a name are taken but give no result.
// Reset (rst_ni low) clears label state, the queue and the output valid.
// Output stalls back up through the queue to in_i.ready.
module dns_name_wire_to_dotted_text_top #(
  parameter int QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  dnsw2t_in_if.sink           in_i,
  dnsw2t_out_if.source        out_o
);

  logic            q_full;
  logic            push;
  dnsw2t_pkg::op_t push_op;
  logic            pop;
  logic            q_valid;
  dnsw2t_pkg::op_t head;

  dnsw2t_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  dnsw2t_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .head_o    (head)
  );

  dnsw2t_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .text_byte_o (out_o.text_byte),
    .has_byte_o  (out_o.has_byte),
    .run_last_o  (out_o.run_last),
    .name_done_o (out_o.name_done)
  );

endmodule

// ===== hw/rtl/dnsw2t_front.sv =====
// ----------------------------------------------------------------------------
// DNS name wire-to-text front end
// Tracks label state per wire byte and turns each byte, but a length that opens a name, into a queued op.
// ----------------------------------------------------------------------------
module dnsw2t_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output dnsw2t_pkg::op_t   push_op_o
);

  logic [7:0] label_left_q, label_left_d;
  logic       at_start_q, at_start_d;
  logic       accept;
  logic       emit;
  logic [7:0] low_ch;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign low_ch     = dnsw2t_pkg::to_lower(in_byte_i);

  // Classify the byte and advance the label state
  always_comb begin
    label_left_d   = label_left_q;
    at_start_d     = at_start_q;
    emit           = 1'b1;
    push_op_o.kind = dnsw2t_pkg::OP_TEXT;
    push_op_o.data = dnsw2t_pkg::CH_DOT;
    push_op_o.done = 1'b0;
    if (label_left_q != 8'd0) begin
      label_left_d   = label_left_q - 8'd1;
      push_op_o.data = low_ch;
      push_op_o.kind = dnsw2t_pkg::plain_char(low_ch) ? dnsw2t_pkg::OP_TEXT
                                                      : dnsw2t_pkg::OP_ESC;
    end else if (in_byte_i == 8'd0) begin
      push_op_o.done = 1'b1;
      if (!at_start_q) begin
        push_op_o.kind = dnsw2t_pkg::OP_MARK;
        push_op_o.data = 8'd0;
        at_start_d     = 1'b1;
      end
    end else begin
      label_left_d = in_byte_i;
      if (at_start_q) begin
        at_start_d = 1'b0;
        emit       = 1'b0;
      end
    end
  end

  assign push_o = accept && emit;

  // Update state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_left_q <= 8'd0;
      at_start_q   <= 1'b1;
    end else if (accept) begin
      label_left_q <= label_left_d;
      at_start_q   <= at_start_d;
    end
  end

endmodule

// ===== hw/rtl/dnsw2t_queue.sv =====
// ----------------------------------------------------------------------------
// DNS name wire-to-text op queue
// Small FIFO of ops between front end and back end.
// ----------------------------------------------------------------------------
module dnsw2t_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dnsw2t_pkg::op_t   push_op_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output dnsw2t_pkg::op_t   head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dnsw2t_pkg::op_t   slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Store pushed ops
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_op_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/dnsw2t_back.sv =====
// ----------------------------------------------------------------------------
// DNS name wire-to-text back end
// Expands queued ops into text results through an output register.
// ----------------------------------------------------------------------------
`include "dns_name_wire_to_dotted_text_top_assert.svh"

module dnsw2t_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  dnsw2t_pkg::op_t   head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        text_byte_o,
  output logic              has_byte_o,
  output logic              run_last_o,
  output logic              name_done_o
);

  logic [1:0] step_q, step_d;
  logic       out_valid_q;
  logic [7:0] text_q, text_d;
  logic       has_q, has_d;
  logic       last_q, last_d;
  logic       done_q, done_d;
  logic       load;
  logic       op_end;

  assign load = !out_valid_q || out_ready_i;

  // Build the result for the current step of the head op
  always_comb begin
    text_d = head_i.data;
    has_d  = 1'b1;
    last_d = 1'b1;
    done_d = head_i.done;
    op_end = 1'b1;
    case (head_i.kind)
      dnsw2t_pkg::OP_TEXT: begin
        text_d = head_i.data;
      end
      dnsw2t_pkg::OP_MARK: begin
        text_d = 8'd0;
        has_d  = 1'b0;
      end
      dnsw2t_pkg::OP_ESC: begin
        done_d = 1'b0;
        op_end = (step_q == dnsw2t_pkg::ESC_LOW);
        last_d = op_end;
        case (step_q)
          dnsw2t_pkg::ESC_SLASH: text_d = dnsw2t_pkg::CH_BSLASH;
          dnsw2t_pkg::ESC_HIGH:  text_d = dnsw2t_pkg::oct_char({1'b0, head_i.data[7:6]});
          dnsw2t_pkg::ESC_MID:   text_d = dnsw2t_pkg::oct_char(head_i.data[5:3]);
          default:               text_d = dnsw2t_pkg::oct_char(head_i.data[2:0]);
        endcase
      end
      default: begin
        text_d = 8'd0;
        has_d  = 1'b0;
      end
    endcase
  end

  assign pop_o  = load && q_valid_i && op_end;
  assign step_d = op_end ? dnsw2t_pkg::ESC_SLASH : step_q + 2'd1;

  // Hold or advance the step counter and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= dnsw2t_pkg::ESC_SLASH;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= q_valid_i;
      if (q_valid_i) begin
        step_q <= step_d;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      text_q <= text_d;
      has_q  <= has_d;
      last_q <= last_d;
      done_q <= done_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_byte_o = text_q;
  assign has_byte_o  = has_q;
  assign run_last_o  = last_q;
  assign name_done_o = done_q;

  // Mid-escape the op stays at the queue head
  `W2T_ASSERT_IMP(a_esc_held, clk_i, rst_ni, step_q != dnsw2t_pkg::ESC_SLASH,
                  q_valid_i && (head_i.kind == dnsw2t_pkg::OP_ESC))
  // A shown result that is not last of its byte has its escape still pending
  `W2T_ASSERT_IMP(a_more_pending, clk_i, rst_ni, out_valid_q && !last_q,
                  step_q != dnsw2t_pkg::ESC_SLASH)
  // A bare marker always ends the name
  `W2T_ASSERT_IMP(a_mark_ends, clk_i, rst_ni, out_valid_q && !has_q, done_q && last_q)
  // Finishing an escape returns the counter to its first step
  `W2T_ASSERT_NXT(a_esc_wrap, clk_i, rst_ni,
                  load && q_valid_i && (step_q == dnsw2t_pkg::ESC_LOW),
                  step_q == dnsw2t_pkg::ESC_SLASH)

endmodule

// ===== test/dns_name_wire_to_dotted_text_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name wire-to-text top level testbench
// Feeds wire-format names through the input channel, a directed table first
// and then random well-formed names mixed with raw byte noise. A local model
// of the label counter and name-start flag predicts results for untyped bytes, and
// each result transfer is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module dns_name_wire_to_dotted_text_top_tb;

  localparam int ClkHalf    = 10;
  localparam int RandItems  = 210;
  localparam int CycleLimit = 300000;
  localparam int DrainWait  = 40;

  typedef struct packed {
    logic [7:0] text;
    logic       has;
    logic       last;
    logic       done;
  } text_res_t;

  typedef struct packed {
    logic [7:0] wire_b;
    logic       typed;
    text_res_t  exp;
  } wire_row_t;

  logic clk_i;
  logic rst_ni;

  dnsw2t_in_if  in_ch ();
  dnsw2t_out_if out_ch ();

  dns_name_wire_to_dotted_text_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Model state
  logic [7:0] bytes_left;
  logic       name_fresh;

  text_res_t  expected_text[$];
  wire_row_t  dir_rows[$];

  // Row under transfer: a typed row replaces the model's results with its own
  logic       row_typed;
  text_res_t  row_exp;

  int unsigned errors;
  int unsigned n_sent;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_escapes;
  int unsigned n_names;
  int unsigned cycles;
  int unsigned src_calm;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  function automatic text_res_t mk_res(input logic [7:0] ch, input logic has,
                                       input logic last, input logic done);
    text_res_t r;
    r.text = ch;
    r.has  = has;
    r.last = last;
    r.done = done;
    return r;
  endfunction

  // Host-name characters that go out unescaped
  function automatic bit is_host_char(input logic [7:0] c);
    return (c >= dnsw2t_pkg::CH_LOWER_A && c <= dnsw2t_pkg::CH_LOWER_Z) ||
           (c >= dnsw2t_pkg::CH_ZERO && c <= dnsw2t_pkg::CH_DIGIT_9) ||
           c == dnsw2t_pkg::CH_DASH || c == dnsw2t_pkg::CH_UNDER;
  endfunction

  task automatic emit(input text_res_t r, input bit keep);
    if (keep) expected_text.push_back(r);
  endtask

  // Advance the model by one wire byte and queue the text it produces
  task automatic predict_wire(input logic [7:0] b, input bit keep);
    logic [7:0] c;
    c = b;
    if (bytes_left != 8'd0) begin
      bytes_left = bytes_left - 8'd1;
      if (c >= dnsw2t_pkg::CH_UPPER_A && c <= dnsw2t_pkg::CH_UPPER_Z) begin
        c = c + dnsw2t_pkg::CASE_OFFSET;
      end
      if (is_host_char(c)) begin
        emit(mk_res(c, 1'b1, 1'b1, 1'b0), keep);
      end else begin
        n_escapes++;
        emit(mk_res(dnsw2t_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0), keep);
        emit(mk_res(dnsw2t_pkg::CH_ZERO + {6'd0, c[7:6]}, 1'b1, 1'b0, 1'b0), keep);
        emit(mk_res(dnsw2t_pkg::CH_ZERO + {5'd0, c[5:3]}, 1'b1, 1'b0, 1'b0), keep);
        emit(mk_res(dnsw2t_pkg::CH_ZERO + {5'd0, c[2:0]}, 1'b1, 1'b1, 1'b0), keep);
      end
    end else if (b == 8'd0) begin
      // root-only name gives a dot, a longer name a bare end marker
      if (name_fresh) begin
        emit(mk_res(dnsw2t_pkg::CH_DOT, 1'b1, 1'b1, 1'b1), keep);
      end else begin
        emit(mk_res(8'd0, 1'b0, 1'b1, 1'b1), keep);
        name_fresh = 1'b1;
      end
    end else begin
      bytes_left = b;
      if (name_fresh) begin
        name_fresh = 1'b0;
      end else begin
        emit(mk_res(dnsw2t_pkg::CH_DOT, 1'b1, 1'b1, 1'b0), keep);
      end
    end
  endtask

  // Input gap: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (src_calm > 0) begin
      src_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) src_calm = $urandom_range(15, 60);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Present one wire byte and hold it until the transfer
  task automatic send_wire(input logic [7:0] b, input logic typed, input text_res_t exp);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    row_typed = typed;
    row_exp   = exp;
    n_sent++;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_wire(b, 1'b0, '0);
  endtask

  task automatic add_row(input logic [7:0] b, input logic typed, input text_res_t exp);
    wire_row_t row;
    row.wire_b = b;
    row.typed  = typed;
    row.exp    = exp;
    dir_rows.push_back(row);
  endtask

  // Label character: mostly host-name characters, some arbitrary bytes
  function automatic logic [7:0] pick_label_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return dnsw2t_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
    if (r < 55) return dnsw2t_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
    if (r < 70) return dnsw2t_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    if (r < 75) return dnsw2t_pkg::CH_DASH;
    if (r < 80) return dnsw2t_pkg::CH_UNDER;
    return 8'($urandom_range(0, 255));
  endfunction

  // One well-formed name with random content; optionally one long label
  task automatic send_name(input bit long_label);
    int labels;
    int len;
    labels = $urandom_range(0, 4);
    if (long_label && labels == 0) labels = 1;
    for (int l = 0; l < labels; l++) begin
      if (long_label && l == 0) len = $urandom_range(128, 150);
      else if ($urandom_range(0, 99) < 6) len = $urandom_range(11, 63);
      else len = $urandom_range(1, 10);
      send_plain(8'(len));
      for (int i = 0; i < len; i++) send_plain(pick_label_char());
    end
    send_plain(8'd0);
  endtask

  // Output stall: random length, mostly short, with calm stretches
  initial begin : sink_side
    int stall;
    int calm;
    int r;
    stall = 0;
    calm  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm > 0) begin
        calm--;
        out_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 4) calm = $urandom_range(20, 80);
        else if (r < 24) stall = $urandom_range(1, 3);
        else if (r < 28) stall = $urandom_range(8, 25);
      end
    end
  end

  // Predict on accepted input, check on accepted result
  always @(posedge clk_i) begin : scoreboard
    text_res_t got;
    text_res_t want;
    logic [3:0] diff;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        n_accepted++;
        predict_wire(in_ch.in_byte, !row_typed);
        if (row_typed) expected_text.push_back(row_exp);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = mk_res(out_ch.text_byte, out_ch.has_byte, out_ch.run_last, out_ch.name_done);
        n_results++;
        if (got.done === 1'b1) n_names++;
        if (expected_text.size() == 0) begin
          errors++;
          $display("%0t: unexpected text result: text=%h has=%b last=%b done=%b",
                   $time, got.text, got.has, got.last, got.done);
        end else begin
          want = expected_text.pop_front();
          diff = {got.text !== want.text, got.has !== want.has,
                  got.last !== want.last, got.done !== want.done};
          if (diff != 4'b0000) begin
            errors++;
            $display("%0t: result %0d mismatch (text/has/last/done differ: %b)",
                     $time, n_results, diff);
            $display("  expected text=%h has=%b last=%b done=%b",
                     want.text, want.has, want.last, want.done);
            $display("  actual   text=%h has=%b last=%b done=%b",
                     got.text, got.has, got.last, got.done);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Run timed out with %0d text results still pending", expected_text.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    row_typed     = 1'b0;
    row_exp       = '0;
    bytes_left    = 8'd0;
    name_fresh    = 1'b1;
    errors        = 0;
    n_sent        = 0;
    n_accepted    = 0;
    n_results     = 0;
    n_escapes     = 0;
    n_names       = 0;
    cycles        = 0;
    src_calm      = 0;
    rst_ni        = 1'b0;

    // Directed table: root names, case folding, class edges, escapes, end marker
    add_row(8'h00, 1'b1, mk_res(dnsw2t_pkg::CH_DOT, 1'b1, 1'b1, 1'b1));
    add_row(8'h00, 1'b1, mk_res(dnsw2t_pkg::CH_DOT, 1'b1, 1'b1, 1'b1));
    add_row(8'h03, 1'b0, '0);
    add_row(8'h41, 1'b1, mk_res(dnsw2t_pkg::CH_LOWER_A, 1'b1, 1'b1, 1'b0));
    add_row(8'h5A, 1'b1, mk_res(dnsw2t_pkg::CH_LOWER_Z, 1'b1, 1'b1, 1'b0));
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h04, 1'b1, mk_res(dnsw2t_pkg::CH_DOT, 1'b1, 1'b1, 1'b0));
    add_row(8'h00, 1'b0, '0);
    add_row(8'h2D, 1'b1, mk_res(dnsw2t_pkg::CH_DASH, 1'b1, 1'b1, 1'b0));
    add_row(8'h5F, 1'b1, mk_res(dnsw2t_pkg::CH_UNDER, 1'b1, 1'b1, 1'b0));
    add_row(8'h30, 1'b1, mk_res(dnsw2t_pkg::CH_ZERO, 1'b1, 1'b1, 1'b0));
    add_row(8'h06, 1'b1, mk_res(dnsw2t_pkg::CH_DOT, 1'b1, 1'b1, 1'b0));
    add_row(8'h2F, 1'b0, '0);
    add_row(8'h3A, 1'b0, '0);
    add_row(8'h40, 1'b0, '0);
    add_row(8'h5B, 1'b0, '0);
    add_row(8'h60, 1'b0, '0);
    add_row(8'h7B, 1'b0, '0);
    add_row(8'h00, 1'b1, mk_res(8'd0, 1'b0, 1'b1, 1'b1));
    add_row(8'h02, 1'b0, '0);
    add_row(8'h39, 1'b1, mk_res(dnsw2t_pkg::CH_DIGIT_9, 1'b1, 1'b1, 1'b0));
    add_row(8'h61, 1'b1, mk_res(dnsw2t_pkg::CH_LOWER_A, 1'b1, 1'b1, 1'b0));
    add_row(8'h00, 1'b1, mk_res(8'd0, 1'b0, 1'b1, 1'b1));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_wire(dir_rows[i].wire_b, dir_rows[i].typed, dir_rows[i].exp);

    // Random names, one with a long label, with some raw byte noise between
    send_name(1'b1);
    while (n_sent < RandItems) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 6)) send_plain(8'($urandom_range(0, 255)));
      end else begin
        send_name(1'b0);
      end
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray results
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Covered %0d wire bytes (%0d escaped) and %0d text results over %0d names.",
             n_accepted, n_escapes, n_results, n_names);
    if (errors == 0 && expected_text.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dnsw2t_pkg.sv
hw/rtl/dnsw2t_if.sv
hw/rtl/dnsw2t_front.sv
hw/rtl/dnsw2t_queue.sv
hw/rtl/dnsw2t_back.sv
hw/rtl/dns_name_wire_to_dotted_text_top.sv
test/dns_name_wire_to_dotted_text_top_tb.sv
